// ===== design/sgsha_pkg.sv =====
// Package for the sorted group SHA-1 aggregator.
// Holds the controller/datapath command and status structs and SHA-1 constants.
// No dependencies.
package sgsha_pkg;

    localparam logic [31:0] SHA_IV [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] PAD_WORD = 32'h80000000;

    // Word source for a push into the message block.
    typedef enum logic [1:0] {
        SRC_ROW  = 2'd0,
        SRC_PAD  = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN  = 2'd3
    } word_src_t;

    typedef struct packed {
        logic      push;        // write one word into the block
        word_src_t src;
        logic      len_hi;      // with SRC_LEN: upper half of the bit length
        logic      add_row;     // update count, sum, length
        logic      open_group;  // latch key of the row
        logic      round_start; // load working vars from hash chain
        logic      round_step;  // perform one SHA-1 round
        logic      round_done;  // fold working vars into the chain
        logic      load_out;    // copy results into output register
        logic      clear;       // return group state to reset values
    } dp_cmd_t;

    typedef struct packed {
        logic       block_full;  // sixteen words held
        logic [3:0] fill;
        logic       last_round;  // round counter at 79
        logic       key_match;   // row key equals open key
    } dp_stat_t;

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < 7'd20) begin
            k = 32'h5A827999;
        end else if (t < 7'd40) begin
            k = 32'h6ED9EBA1;
        end else if (t < 7'd60) begin
            k = 32'h8F1BBCDC;
        end else begin
            k = 32'hCA62C1D6;
        end
        return k;
    endfunction

endpackage

// ===== design/sorted_group_sha1_aggregator_unit.sv =====
// Top level of the sorted group SHA-1 aggregator.
// Instantiates sgsha_ctrl and sgsha_datapath; depends on sgsha_pkg.
//
// Rows arrive sorted by key; each run of equal keys is one group, and for
// each group the block returns its key, the SHA-1 digest of the values as
// little-endian bytes, a saturating row count and a wrapping 64-bit sum.
// A row that completes a 64-byte block starts its compression in the
// single round unit (load the working variables, 80 rounds, fold the chain),
// and no row is taken until that is done. Closing a group pads and compresses
// one or two blocks, the second when the padding spills into it. No item is
// taken while a result waits in the output register.
// A key change holds the new row inside while the old group is closed.
module sorted_group_sha1_aggregator_unit
    import sgsha_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,  // [31:0] group_key, [63:32] value
    input  logic          s_tuser,  // cmd: 1 = flush the open group
    output logic          m_tvalid,
    input  logic          m_tready,
    // [31:0] result_key, [63:32] digest_w0 .. [191:160] digest_w4,
    // [223:192] row_count, [287:224] row_total
    output logic [287:0]  m_tdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic signed [31:0] in_key;
    logic signed [31:0] in_value;
    logic signed [31:0] res_key;
    logic [31:0]        res_h [5];
    logic [31:0]        res_count;
    logic signed [63:0] res_total;

    // The row that triggers a group close is kept here until it is replayed.
    logic [63:0] hold_reg;
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            hold_reg <= s_tdata;
        end
    end
    assign in_key   = (s_tvalid && s_tready) ? s_tdata[31:0]  : hold_reg[31:0];
    assign in_value = (s_tvalid && s_tready) ? s_tdata[63:32] : hold_reg[63:32];

    sgsha_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_flush (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    sgsha_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_key    (in_key),
        .in_value  (in_value),
        .res_key   (res_key),
        .res_h     (res_h),
        .res_count (res_count),
        .res_total (res_total)
    );

    assign m_tdata = {res_total, res_count, res_h[4], res_h[3], res_h[2],
                      res_h[1], res_h[0], res_key};

endmodule

// ===== design/sgsha_datapath.sv =====
// Datapath of the sorted group SHA-1 aggregator: block buffer, round unit,
// hash chain, count, sum and length. Depends on sgsha_pkg.
module sgsha_datapath
    import sgsha_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic signed [31:0]  in_key,
    input  logic signed [31:0]  in_value,
    output logic signed [31:0]  res_key,
    output logic [31:0]         res_h [5],
    output logic [31:0]         res_count,
    output logic signed [63:0]  res_total
);

    logic [31:0] w_reg [16];
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [4:0]  fill_reg;
    logic [6:0]  t_reg;
    logic [63:0] bytes_reg;
    logic [31:0] count_reg;
    logic [63:0] total_reg;
    logic [31:0] key_reg;

    logic [31:0] push_word;
    logic [31:0] be_value;
    logic [63:0] bits;
    logic [31:0] wt, wx, f;
    logic [31:0] tmp;

    assign be_value = {in_value[7:0], in_value[15:8], in_value[23:16], in_value[31:24]};
    assign bits     = {bytes_reg[60:0], 3'b000};

    always_comb begin
        case (cmd.src)
            SRC_ROW:  push_word = be_value;
            SRC_PAD:  push_word = PAD_WORD;
            SRC_ZERO: push_word = '0;
            SRC_LEN:  push_word = cmd.len_hi ? bits[63:32] : bits[31:0];
            default:  push_word = '0;
        endcase
    end

    // The schedule is kept in place: w_reg[t mod 16] is overwritten with w[t].
    always_comb begin
        wx = w_reg[4'(t_reg + 7'd13)] ^ w_reg[4'(t_reg + 7'd8)]
           ^ w_reg[4'(t_reg + 7'd2)] ^ w_reg[t_reg[3:0]];
        wt = (t_reg < 7'd16) ? w_reg[t_reg[3:0]] : {wx[30:0], wx[31]};
        if (t_reg < 7'd20) begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
        end else if (t_reg < 7'd40 || t_reg >= 7'd60) begin
            f = b_reg ^ c_reg ^ d_reg;
        end else begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
        end
        tmp = {a_reg[26:0], a_reg[31:27]} + f + e_reg + round_k(t_reg) + wt;
    end

    assign stat.block_full = fill_reg[4];
    assign stat.fill       = fill_reg[3:0];
    assign stat.last_round = (t_reg == 7'd79);
    assign stat.key_match  = (in_key == key_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            for (int i = 0; i < 5; i++) begin
                h_reg[i] <= SHA_IV[i];
            end
            fill_reg  <= '0;
            bytes_reg <= '0;
            count_reg <= '0;
            total_reg <= '0;
        end else begin
            if (cmd.push) begin
                w_reg[fill_reg[3:0]] <= push_word;
                fill_reg <= fill_reg + 5'd1;
            end
            if (cmd.add_row) begin
                bytes_reg <= bytes_reg + 64'd4;
                if (count_reg != '1) begin
                    count_reg <= count_reg + 32'd1;
                end
                total_reg <= total_reg + {{32{in_value[31]}}, in_value};
            end
            if (cmd.round_step) begin
                w_reg[t_reg[3:0]] <= wt;
            end
            if (cmd.round_done) begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
                fill_reg <= '0;
            end
        end
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cmd.open_group) begin
            key_reg <= in_key;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.round_start) begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
            t_reg <= '0;
        end else if (cmd.round_step) begin
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
            t_reg <= t_reg + 7'd1;
        end
        if (cmd.load_out) begin
            res_key   <= key_reg;
            res_h     <= h_reg;
            res_count <= count_reg;
            res_total <= total_reg;
        end
    end

endmodule

// ===== design/sgsha_ctrl.sv =====
// Controller of the sorted group SHA-1 aggregator: sequences rows, padding,
// compression rounds and result hand-off. Depends on sgsha_pkg.
module sgsha_ctrl
    import sgsha_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      in_flush,
    output logic      m_tvalid,
    input  logic      m_tready,
    output dp_cmd_t   cmd,
    input  dp_stat_t  stat
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_PAD   = 8'b00000010,
        ST_ZERO  = 8'b00000100,
        ST_LENHI = 8'b00001000,
        ST_LENLO = 8'b00010000,
        ST_ROUND = 8'b00100000,
        ST_EMIT  = 8'b01000000,
        ST_DONE  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic   open_reg, open_next;
    logic   pend_reg, pend_next;   // a row waits behind the group being closed
    logic   padding_reg, padding_next;
    logic   outv_reg, outv_next;
    // Marks that the block now being compressed carries the length words.
    logic   final_blk_reg, final_blk_next;
    logic   take;

    assign m_tvalid = outv_reg;
    // The output register must be free before a group can be closed, and a
    // held row must be replayed before a new item is taken.
    assign s_tready = (state_reg == ST_IDLE) && !stat.block_full && !outv_reg && !pend_reg;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        state_next   = state_reg;
        open_next    = open_reg;
        pend_next    = pend_reg;
        padding_next = padding_reg;
        outv_next    = outv_reg && !m_tready;
        cmd          = '0;
        cmd.src      = SRC_ROW;
        unique case (state_reg)
            ST_IDLE: begin
                if (stat.block_full) begin
                    cmd.round_start = 1'b1;
                    state_next      = ST_ROUND;
                end else if (pend_reg) begin
                    pend_next      = 1'b0;
                    open_next      = 1'b1;
                    cmd.open_group = 1'b1;
                    cmd.push       = 1'b1;
                    cmd.add_row    = 1'b1;
                end else if (take) begin
                    if (in_flush) begin
                        if (open_reg) begin
                            state_next = ST_PAD;
                        end
                    end else if (open_reg && !stat.key_match) begin
                        pend_next  = 1'b1;
                        state_next = ST_PAD;
                    end else begin
                        open_next      = 1'b1;
                        cmd.open_group = !open_reg;
                        cmd.push       = 1'b1;
                        cmd.add_row    = 1'b1;
                    end
                end
            end
            ST_PAD: begin
                cmd.push     = 1'b1;
                cmd.src      = SRC_PAD;
                padding_next = 1'b1;
                state_next   = (stat.fill == 4'd15) ? ST_ROUND : ST_ZERO;
                cmd.round_start = (stat.fill == 4'd15);
            end
            ST_ZERO: begin
                if (stat.block_full) begin
                    cmd.round_start = 1'b1;
                    state_next      = ST_ROUND;
                end else if (stat.fill == 4'd14) begin
                    state_next = ST_LENHI;
                end else begin
                    cmd.push = 1'b1;
                    cmd.src  = SRC_ZERO;
                end
            end
            ST_LENHI: begin
                cmd.push   = 1'b1;
                cmd.src    = SRC_LEN;
                cmd.len_hi = 1'b1;
                state_next = ST_LENLO;
            end
            ST_LENLO: begin
                cmd.push   = 1'b1;
                cmd.src    = SRC_LEN;
                state_next = ST_ZERO;
                padding_next = 1'b0;
            end
            ST_ROUND: begin
                cmd.round_step = 1'b1;
                if (stat.last_round) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                cmd.round_done = 1'b1;
                if (padding_reg) begin
                    state_next = ST_ZERO;
                end else if (final_blk_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE: begin
                // The chain holds the final digest now; hand the group out and
                // return the group state to its reset values at the same edge.
                cmd.load_out = 1'b1;
                cmd.clear    = 1'b1;
                outv_next    = 1'b1;
                open_next    = 1'b0;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        final_blk_next = final_blk_reg;
        if (state_reg == ST_LENLO) begin
            final_blk_next = 1'b1;
        end else if (state_reg == ST_EMIT) begin
            final_blk_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            open_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            padding_reg   <= 1'b0;
            outv_reg      <= 1'b0;
            final_blk_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            pend_reg      <= pend_next;
            padding_reg   <= padding_next;
            outv_reg      <= outv_next;
            final_blk_reg <= final_blk_next;
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for sorted_group_sha1_aggregator_unit.
// Predicts per-group SHA-1 digest, row count and sum, then checks each result item.
// Depends on sgsha_pkg and the RTL of the aggregator unit.
module testbench
    import sgsha_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_ROW   = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;
    localparam int   STALL_LIMIT = 20000;

    typedef struct packed {
        logic        cmd;
        logic [31:0] key;
        logic [31:0] value;
    } row_item_t;

    typedef struct packed {
        logic [63:0] total;
        logic [31:0] count;
        logic [31:0] h4;
        logic [31:0] h3;
        logic [31:0] h2;
        logic [31:0] h1;
        logic [31:0] h0;
        logic [31:0] key;
    } group_result_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [63:0]   s_tdata = '0;   // [31:0] group_key, [63:32] value
    logic          s_tuser = 1'b0; // cmd
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [287:0]  m_tdata;        // key, digest w0..w4, count, total (lowest first)

    sorted_group_sha1_aggregator_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // Predictor state for the open group.
    logic [31:0] chain [5];
    logic [31:0] blk [16];
    int unsigned fill;
    logic [63:0] byte_len;
    logic [31:0] cur_key;
    logic        is_open;
    logic [31:0] cnt;
    logic [63:0] sum;

    row_item_t     pending_rows [$];
    group_result_t expected_groups [$];
    int  errors = 0;
    int  results_seen = 0;
    int  send_idle_pct = 26;
    int  recv_idle_pct = 55;
    bit  stim_done = 1'b0;
    int  quiet_cycles = 0;

    function automatic logic [31:0] rol(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic sha_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, tmp;
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                wt = rol(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16], 1);
                w[t % 16] = wt;
            end
            if (t < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (t < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            tmp = rol(a, 5) + f + e + k + wt;
            e = d; d = c; c = rol(b, 30); b = a; a = tmp;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endtask

    task automatic append_word(logic [31:0] w);
        blk[fill] = w;
        fill++;
        if (fill == 16) begin
            sha_compress();
            fill = 0;
        end
    endtask

    task automatic restart_group();
        for (int i = 0; i < 5; i++) chain[i] = SHA_IV[i];
        for (int i = 0; i < 16; i++) blk[i] = '0;
        fill = 0; byte_len = '0; cnt = '0; sum = '0;
    endtask

    task automatic close_group();
        group_result_t r;
        logic [63:0] bits;
        bits = byte_len << 3;
        append_word(PAD_WORD);
        while (fill != 14) append_word('0);
        append_word(bits[63:32]);
        append_word(bits[31:0]);
        r.key = cur_key;
        r.h0 = chain[0]; r.h1 = chain[1]; r.h2 = chain[2]; r.h3 = chain[3]; r.h4 = chain[4];
        r.count = cnt; r.total = sum;
        expected_groups.insert(expected_groups.size(), r);
        restart_group();
        is_open = 1'b0;
    endtask

    // Applies one accepted item to the predictor.
    task automatic predict_item(row_item_t it);
        if (it.cmd == CMD_FLUSH) begin
            if (is_open) close_group();
            return;
        end
        if (is_open && it.key != cur_key) close_group();
        if (!is_open) begin
            cur_key = it.key;
            is_open = 1'b1;
        end
        append_word({it.value[7:0], it.value[15:8], it.value[23:16], it.value[31:24]});
        byte_len += 64'd4;
        if (cnt != 32'hFFFF_FFFF) cnt++;
        sum += {{32{it.value[31]}}, it.value};
    endtask

    // Driver: an item stays valid until accepted; the next one follows at once or after a gap.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_item('{s_tuser, s_tdata[31:0], s_tdata[63:32]});
                void'(pending_rows.pop_front());
            end
            if (!s_tvalid || s_tready) begin
                if (pending_rows.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_rows[0].cmd;
                    s_tdata  <= {pending_rows[0].value, pending_rows[0].key};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure and field-by-field comparison.
    always @(posedge aclk) begin
        group_result_t got, want;
        if (aresetn) begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                results_seen++;
                if (expected_groups.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = expected_groups.pop_front();
                    if (got.key !== want.key) begin
                        $display("%0t: key expected %h actual %h", $time, want.key, got.key);
                        errors++;
                    end
                    if (got.h0 !== want.h0) begin
                        $display("%0t: digest_w0 expected %h actual %h", $time, want.h0, got.h0);
                        errors++;
                    end
                    if (got.h1 !== want.h1) begin
                        $display("%0t: digest_w1 expected %h actual %h", $time, want.h1, got.h1);
                        errors++;
                    end
                    if (got.h2 !== want.h2) begin
                        $display("%0t: digest_w2 expected %h actual %h", $time, want.h2, got.h2);
                        errors++;
                    end
                    if (got.h3 !== want.h3) begin
                        $display("%0t: digest_w3 expected %h actual %h", $time, want.h3, got.h3);
                        errors++;
                    end
                    if (got.h4 !== want.h4) begin
                        $display("%0t: digest_w4 expected %h actual %h", $time, want.h4, got.h4);
                        errors++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: row_count expected %h actual %h", $time, want.count,
                                 got.count);
                        errors++;
                    end
                    if (got.total !== want.total) begin
                        $display("%0t: row_total expected %h actual %h", $time, want.total,
                                 got.total);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog: a run that stops moving items is a failure.
    always @(posedge aclk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no item accepted for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_row(logic [31:0] k, logic [31:0] v);
        row_item_t it;
        it = '{CMD_ROW, k, v};
        pending_rows.insert(pending_rows.size(), it);
    endtask

    task automatic queue_flush();
        row_item_t it;
        it = '{CMD_FLUSH, $urandom, $urandom};
        pending_rows.insert(pending_rows.size(), it);
    endtask

    task automatic wait_drained();
        while (pending_rows.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_groups.size() != 0) @(posedge aclk);
    endtask

    // Random groups: short runs of equal keys, mostly rising in order, a few long ones that
    // cross several blocks, with occasional flushes and repeated keys after a flush.
    task automatic queue_random(int n_items);
        logic [31:0] k;
        int len;
        k = $urandom;
        while (n_items > 0) begin
            case ($urandom_range(9))
                0: len = $urandom_range(14, 40);
                1: len = 0;
                default: len = $urandom_range(1, 6);
            endcase
            for (int i = 0; i < len; i++) queue_row(k, $urandom);
            n_items -= len;
            if ($urandom_range(4) == 0) begin
                queue_flush();
                n_items--;
            end
            if ($urandom_range(5) != 0) k = k + $urandom_range(1, 1000);
            else if ($urandom_range(1) == 0) k = $urandom;
        end
        queue_flush();
    endtask

    initial begin
        restart_group();
        cur_key = '0;
        is_open = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: flush with nothing open, extreme keys and values, a row after a flush that
        // reuses the old key, a group whose padding spills into a second block, one filling a block.
        queue_flush();
        queue_row(32'h8000_0000, 32'h8000_0000);
        queue_row(32'h8000_0000, 32'hFFFF_FFFF);
        queue_row(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_flush();
        queue_flush();
        queue_row(32'h7FFF_FFFF, 32'h0000_0000);
        queue_row(32'h0000_0000, 32'hA5A5_5A5A);
        queue_row(32'hFFFF_FFFF, 32'h5A5A_A5A5);
        queue_flush();
        for (int i = 0; i < 14; i++) queue_row(32'h0000_1234, $urandom);
        queue_flush();
        // Pause until every expected group has come back.
        wait_drained();
        queue_row(32'h0000_0042, 32'h1111_1111);
        for (int i = 0; i < 15; i++) queue_row(32'h0000_0042, $urandom);
        queue_flush();

        queue_random(350);
        wait_drained();
        send_idle_pct = 55; recv_idle_pct = 26;
        queue_random(350);
        wait_drained();
        send_idle_pct = 0; recv_idle_pct = 0;
        queue_random(350);
        wait_drained();
        repeat (400) @(posedge aclk);

        $display("Ran about 1100 items in sorted key runs with flushes and two idling mixes;");
        $display("%0d group results checked for key, SHA-1 digest, count and sum.", results_seen);
        if (errors == 0 && expected_groups.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
design/sgsha_pkg.sv
design/sgsha_datapath.sv
design/sgsha_ctrl.sv
design/sorted_group_sha1_aggregator_unit.sv
sim/testbench.sv
